// ===== src/mcr_pkg.sv =====
// shared constants and types of the midpoint circle rasterizer
package mcr_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int DEC_BITS    = RADIUS_BITS + 4;
  localparam int CENTRE_BITS = 11;
  localparam int COORD_BITS  = 13;
  localparam int SET_POINTS  = 8;
  localparam int CNT_BITS    = $clog2(SET_POINTS);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [CNT_BITS-1:0] LAST_POINT = CNT_BITS'(SET_POINTS - 1);

  typedef logic [CENTRE_BITS-1:0]       centre_t;
  typedef logic [RADIUS_BITS-1:0]       offset_t;
  typedef logic [DEC_BITS-1:0]          dec_t;
  typedef logic [COORD_BITS-1:0]        ucoord_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  // one octant point and its centre, mirrored eight ways by the emitter
  typedef struct packed {
    centre_t cx;
    centre_t cy;
    offset_t ox;
    offset_t oy;
    logic    is_last;
  } mcr_set_t;

endpackage

// ===== src/mcr_if.sv =====
// valid/ready channels of the circle rasterizer
interface mcr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [mcr_pkg::CENTRE_BITS-1:0] center_x;
  logic [mcr_pkg::CENTRE_BITS-1:0] center_y;
  logic [9:0]                    radius;

  modport source (output valid, func, center_x, center_y, radius, input ready);
  modport sink   (input valid, func, center_x, center_y, radius, output ready);
endinterface

interface mcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcr_pkg::COORD_BITS-1:0] point_x;
  logic signed [mcr_pkg::COORD_BITS-1:0] point_y;
  logic                                 last;

  modport source (output valid, point_x, point_y, last, input ready);
  modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

// ===== src/mcr_core.sv =====
// circle state registers, decision update and end-of-circle look-ahead
module mcr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              func,
  input  mcr_pkg::centre_t  cx_in,
  input  mcr_pkg::centre_t  cy_in,
  input  mcr_pkg::offset_t  r_in,
  output logic              set_load,
  output mcr_pkg::mcr_set_t set_data
);

  typedef struct packed {
    logic [mcr_pkg::RADIUS_BITS:0]          nx;
    logic signed [mcr_pkg::RADIUS_BITS+1:0] ny;
    mcr_pkg::dec_t                          nd;
  } adv_t;

  function automatic adv_t advance(mcr_pkg::offset_t x, mcr_pkg::offset_t y,
                                   mcr_pkg::dec_t d);
    adv_t          a;
    mcr_pkg::dec_t x4;
    mcr_pkg::dec_t y4;
    x4 = mcr_pkg::dec_t'({x, 2'b00});
    y4 = mcr_pkg::dec_t'({y, 2'b00});
    a.nx = {1'b0, x} + 1'b1;
    if (d[mcr_pkg::DEC_BITS-1]) begin
      a.nd = d + x4 + mcr_pkg::dec_t'(6);
      a.ny = $signed({2'b00, y});
    end else begin
      a.nd = d + (x4 - y4) + mcr_pkg::dec_t'(10);
      a.ny = $signed({2'b00, y} - 1'b1);
    end
    return a;
  endfunction

  mcr_pkg::centre_t cx_r, cy_r;
  mcr_pkg::offset_t ox_r, oy_r;
  mcr_pkg::dec_t    dec_r;
  logic             running_r;

  mcr_pkg::offset_t ox_nxt, oy_nxt;
  mcr_pkg::dec_t    dec_nxt;
  mcr_pkg::centre_t cx_nxt, cy_nxt;
  adv_t             step_a;
  adv_t             look_a;
  logic             is_start;
  logic             is_last;

  assign is_start = (func == mcr_pkg::FUNC_START);
  assign step_a   = advance(ox_r, oy_r, dec_r);

  always_comb begin
    if (is_start) begin
      ox_nxt  = '0;
      oy_nxt  = r_in;
      dec_nxt = mcr_pkg::dec_t'(3) - mcr_pkg::dec_t'({r_in, 1'b0});
      cx_nxt  = cx_in;
      cy_nxt  = cy_in;
    end else begin
      ox_nxt  = step_a.nx[mcr_pkg::RADIUS_BITS-1:0];
      oy_nxt  = step_a.ny[mcr_pkg::RADIUS_BITS-1:0];
      dec_nxt = step_a.nd;
      cx_nxt  = cx_r;
      cy_nxt  = cy_r;
    end
  end

  // the set is final when the following offset would cross the diagonal
  assign look_a  = advance(ox_nxt, oy_nxt, dec_nxt);
  assign is_last = look_a.ny < $signed({1'b0, look_a.nx});

  // a step while idle is taken and dropped
  assign set_load = acc && (is_start || running_r);

  assign set_data.cx      = cx_nxt;
  assign set_data.cy      = cy_nxt;
  assign set_data.ox      = ox_nxt;
  assign set_data.oy      = oy_nxt;
  assign set_data.is_last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cx_r      <= '0;
      cy_r      <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
      dec_r     <= '0;
    end else if (set_load) begin
      running_r <= !is_last;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      ox_r      <= ox_nxt;
      oy_r      <= oy_nxt;
      dec_r     <= dec_nxt;
    end
  end

endmodule

// ===== src/mcr_emit.sv =====
// set register and eight-way mirror sequencer feeding the point channel
module mcr_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              set_load,
  input  mcr_pkg::mcr_set_t set_data,
  input  logic              out_ready,
  output logic              take_ok,
  output logic              out_valid,
  output mcr_pkg::coord_t   point_x,
  output mcr_pkg::coord_t   point_y,
  output logic              last
);

  mcr_pkg::mcr_set_t set_r;
  logic              set_valid_r;
  mcr_pkg::cnt_t     cnt_r;

  mcr_pkg::offset_t  a, b;
  mcr_pkg::ucoord_t  cx, cy, ea, eb;
  logic              at_end;
  logic              out_acc;

  assign at_end  = (cnt_r == mcr_pkg::LAST_POINT);
  assign out_acc = set_valid_r && out_ready;
  // next set may load while the eighth word of this one is taken
  assign take_ok = !set_valid_r || (at_end && out_ready);

  // point order: x/y pairs first, then swapped pairs; bit1 negates x, bit0 y
  always_comb begin
    a  = cnt_r[2] ? set_r.oy : set_r.ox;
    b  = cnt_r[2] ? set_r.ox : set_r.oy;
    cx = mcr_pkg::ucoord_t'(set_r.cx);
    cy = mcr_pkg::ucoord_t'(set_r.cy);
    ea = mcr_pkg::ucoord_t'(a);
    eb = mcr_pkg::ucoord_t'(b);
  end

  assign point_x   = cnt_r[1] ? $signed(cx - ea) : $signed(cx + ea);
  assign point_y   = cnt_r[0] ? $signed(cy - eb) : $signed(cy + eb);
  assign last      = set_r.is_last && at_end;
  assign out_valid = set_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (set_load) begin
      set_valid_r <= 1'b1;
      cnt_r       <= '0;
    end else if (out_acc) begin
      if (at_end) begin
        set_valid_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (set_load) begin
      set_r <= set_data;
    end
  end

endmodule

// ===== src/midpoint_circle_rasterizer_top.sv =====
// top level of the midpoint circle rasterizer
// Each accepted word either starts a circle (centre and radius) or advances it by one
// octant step; a start or a step on a running circle yields eight mirrored points, one per
// cycle unless the output stalls, the last of a circle flagged by last, while a step on an
// idle block yields nothing. The point sequencer sets the pace: an item that yields points
// is accepted in the cycle its predecessor's eighth point leaves, or at once when no points
// are pending; an item that yields nothing is accepted under the same condition and dropped.
module midpoint_circle_rasterizer_top (
  input logic      clk,
  input logic      rst_n,
  mcr_in_if.sink   in_ch,
  mcr_out_if.source out_ch
);

  logic              acc;
  logic              take_ok;
  logic              set_load;
  mcr_pkg::mcr_set_t set_data;

  assign in_ch.ready = take_ok;
  assign acc         = in_ch.valid && take_ok;

  mcr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .func     (in_ch.func),
    .cx_in    (in_ch.center_x),
    .cy_in    (in_ch.center_y),
    .r_in     (mcr_pkg::offset_t'(in_ch.radius)),
    .set_load (set_load),
    .set_data (set_data)
  );

  mcr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_load  (set_load),
    .set_data  (set_data),
    .out_ready (out_ch.ready),
    .take_ok   (take_ok),
    .out_valid (out_ch.valid),
    .point_x   (out_ch.point_x),
    .point_y   (out_ch.point_y),
    .last      (out_ch.last)
  );

endmodule

// ===== dv/midpoint_circle_rasterizer_top_tb.sv =====
// self-checking testbench of the midpoint circle rasterizer top level
module midpoint_circle_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAWN_TARGET = 125;
  localparam int CALM_AT      = 110;
  localparam int HOLD_AT      = 40;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    mcr_pkg::coord_t x;
    mcr_pkg::coord_t y;
    logic            last;
  } point_t;

  // tracks the circle being drawn and the points still owed by the block
  class circle_tracer;
    mcr_pkg::centre_t cx;
    mcr_pkg::centre_t cy;
    int               ox;
    int               oy;
    mcr_pkg::dec_t    dec;
    bit               running;
    point_t           points_due[$];
    int               errors;

    function new();
      cx      = '0;
      cy      = '0;
      ox      = 0;
      oy      = 0;
      dec     = '0;
      running = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return points_due.size();
    endfunction

    // one midpoint step from (x, y) with decision d
    function void advance(input int x, input int y, input mcr_pkg::dec_t d,
                          output int nx, output int ny, output mcr_pkg::dec_t nd);
      int t;
      if ($signed(d) < 0) begin
        t  = $signed(d) + 4 * x + 6;
        ny = y;
      end else begin
        t  = $signed(d) + 4 * (x - y) + 10;
        ny = y - 1;
      end
      nd = mcr_pkg::dec_t'(t);
      nx = x + 1;
    endfunction

    function void queue_set();
      int            nx;
      int            ny;
      int            a;
      int            b;
      int            sx;
      int            sy;
      mcr_pkg::dec_t nd;
      bit            closing;
      point_t        p;
      advance(ox, oy, dec, nx, ny, nd);
      closing = (ny < nx);
      for (int k = 0; k < mcr_pkg::SET_POINTS; k++) begin
        a      = (k < 4) ? ox : oy;
        b      = (k < 4) ? oy : ox;
        sx     = (k & 2) ? -1 : 1;
        sy     = (k & 1) ? -1 : 1;
        p.x    = mcr_pkg::coord_t'(int'(cx) + sx * a);
        p.y    = mcr_pkg::coord_t'(int'(cy) + sy * b);
        p.last = (k == mcr_pkg::SET_POINTS - 1) && closing;
        points_due.push_back(p);
      end
      if (closing) running = 1'b0;
    endfunction

    // returns the number of points the word causes
    function int trace_word(logic f, mcr_pkg::centre_t x, mcr_pkg::centre_t y,
                            logic [9:0] r);
      int            nx;
      int            ny;
      mcr_pkg::dec_t nd;
      if (f == mcr_pkg::FUNC_START) begin
        cx      = x;
        cy      = y;
        ox      = 0;
        oy      = int'(r);
        dec     = mcr_pkg::dec_t'(3 - 2 * int'(r));
        running = 1'b1;
        queue_set();
        return mcr_pkg::SET_POINTS;
      end
      if (!running) return 0;
      advance(ox, oy, dec, nx, ny, nd);
      ox  = nx;
      oy  = ny;
      dec = nd;
      queue_set();
      return mcr_pkg::SET_POINTS;
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_point(mcr_pkg::coord_t px, mcr_pkg::coord_t py, logic last);
      point_t p;
      if (points_due.size() == 0) begin
        report($sformatf("unexpected point (%0d, %0d) last=%0b", px, py, last));
      end else begin
        p = points_due.pop_front();
        if (px !== p.x) report($sformatf("point_x %0d, expected %0d", px, p.x));
        if (py !== p.y) report($sformatf("point_y %0d, expected %0d", py, p.y));
        if (last !== p.last) report($sformatf("last %0b, expected %0b", last, p.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  mcr_in_if  in_ch();
  mcr_out_if out_ch();

  midpoint_circle_rasterizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  circle_tracer tracer;
  bit           calm;
  bit           hold_req;
  bit           hold_done;
  int           drawn_words;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word, hold it until taken, then log it with the tracer
  task automatic send_word(logic f, mcr_pkg::centre_t x, mcr_pkg::centre_t y,
                           logic [9:0] r);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.center_x <= x;
    in_ch.center_y <= y;
    in_ch.radius   <= r;
    do @(posedge clk); while (!in_ch.ready);
    n = tracer.trace_word(f, x, y, r);
    if (n > 0) drawn_words++;
  endtask

  // centre and radius are don't-care on a step, so they carry noise
  task automatic send_step();
    send_word(mcr_pkg::FUNC_STEP, mcr_pkg::centre_t'($urandom),
              mcr_pkg::centre_t'($urandom), 10'($urandom));
  endtask

  task automatic finish_circle();
    while (tracer.running) send_step();
  endtask

  task automatic random_circle();
    int         pick;
    logic [9:0] rad;
    pick = $urandom_range(0, 19);
    if (pick < 14) rad = 10'($urandom_range(0, 24));
    else if (pick < 18) rad = 10'($urandom_range(25, 80));
    else rad = 10'($urandom);
    send_word(mcr_pkg::FUNC_START, mcr_pkg::centre_t'($urandom),
              mcr_pkg::centre_t'($urandom), rad);
    if (rad <= 80 && $urandom_range(0, 9) < 7) begin
      finish_circle();
      repeat ($urandom_range(0, 2)) send_step();
    end else begin
      // left to the next start, which breaks it off if it is still running
      repeat ($urandom_range(0, 12)) send_step();
    end
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracer.check_point(out_ch.point_x, out_ch.point_y, out_ch.last);
  end

  // ends the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("** midpoint_circle_rasterizer_top: FAILED **");
    $finish;
  end

  initial begin
    tracer         = new();
    calm           = 1'b0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    drawn_words    = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= mcr_pkg::FUNC_START;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.radius   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // radius zero: eight copies of the centre, final at once
    send_word(mcr_pkg::FUNC_START, mcr_pkg::centre_t'(1000), mcr_pkg::centre_t'(1000),
              10'd0);
    // step on an idle block
    send_step();
    // largest radius at both corners, the second start drops the first circle
    send_word(mcr_pkg::FUNC_START, '0, '0, 10'd1023);
    send_step();
    send_step();
    send_word(mcr_pkg::FUNC_START, '1, '1, 10'd1023);
    send_step();
    // radius one finishes on its start set
    send_word(mcr_pkg::FUNC_START, mcr_pkg::centre_t'(5), mcr_pkg::centre_t'(7), 10'd1);
    send_step();
    // small circles run out to the diagonal, then one step past the end
    send_word(mcr_pkg::FUNC_START, mcr_pkg::centre_t'(100), mcr_pkg::centre_t'(200),
              10'd5);
    finish_circle();
    send_step();
    send_word(mcr_pkg::FUNC_START, '1, '0, 10'd3);
    finish_circle();
    send_word(mcr_pkg::FUNC_START, mcr_pkg::centre_t'(1024), mcr_pkg::centre_t'(3),
              10'd8);
    finish_circle();

    drawn_words = 0;
    while (drawn_words < DRAWN_TARGET) begin
      if (drawn_words >= HOLD_AT && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (drawn_words >= CALM_AT) calm = 1'b1;
      random_circle();
    end
    in_ch.valid <= 1'b0;

    while (tracer.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracer.errors == 0 && tracer.pending() == 0) begin
      $display("** midpoint_circle_rasterizer_top: PASSED **");
    end else begin
      $display("** midpoint_circle_rasterizer_top: FAILED **");
    end
    $finish;
  end

endmodule
